@@ src/pnc_pkg.sv @@
// ----------------------------------------------------------------------------
// pnc_pkg
// Shared types and constants for the palette nearest colour engine.
// ----------------------------------------------------------------------------
package pnc_pkg;

   localparam int unsigned INDEX_W = 8;    // width of the entry index fields
   localparam int unsigned CHAN_W  = 8;    // width of one colour channel
   localparam int unsigned DIST_W  = 10;   // holds three channel differences
   localparam int unsigned RGB_W   = 16;   // packed red5 green6 blue5
   localparam int unsigned ACT_W   = 2;

   typedef enum logic [ACT_W-1:0] {
      ACT_WRITE     = 2'd0,
      ACT_TRANSLATE = 2'd1,
      ACT_SEARCH    = 2'd2
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_XLATE  = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } entry_type;

   localparam int unsigned ENTRY_W = $bits(entry_type);

endpackage

@@ src/pnc_ram.sv @@
// ----------------------------------------------------------------------------
// pnc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module pnc_ram #(
   parameter int unsigned WIDTH = 24,
   parameter int unsigned DEPTH = 256
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/palette_nearest_color_engine_core.sv @@
// ----------------------------------------------------------------------------
// palette_nearest_color_engine_core
// Palette store with RGB565 translate and nearest colour (L1) search.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item: an action plus entry index and colour. Action
//   write stores red/green/blue at the entry, translate packs the stored
//   entry as RGB565, search scans every entry for the least sum of absolute
//   channel differences (lowest index wins a tie). Every item gives exactly
//   one rsp_* item; fields not produced by the action read zero.
//   A write or unused action passes from acceptance through ST_FINISH to
//   the output register, a translate through ST_XLATE and ST_FINISH, a
//   search through an ST_SCAN sweep of every entry and then ST_FINISH. One
//   item is in flight at a time; req_ready returns in the cycle the result
//   appears in the output register. The search rate is set by the single
//   read port of the palette RAM feeding one distance/compare unit, one
//   entry per cycle.
//   Reset clears the per-entry valid flags, so the whole palette reads as
//   black at once; no clearing pass is run.
//   A stalled receiver holds rsp_* steady. The block still takes a new item
//   and works on it, but holds its result until the output register frees.
// ----------------------------------------------------------------------------
module palette_nearest_color_engine_core
   import pnc_pkg::*;
#(
   parameter int unsigned PALETTE_ENTRIES = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [ACT_W-1:0]      req_action,
   input  logic [INDEX_W-1:0]    req_entry_index,
   input  logic [CHAN_W-1:0]     req_red,
   input  logic [CHAN_W-1:0]     req_green,
   input  logic [CHAN_W-1:0]     req_blue,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [INDEX_W-1:0]    rsp_best_index,
   output logic [DIST_W-1:0]     rsp_best_distance,
   output logic [RGB_W-1:0]      rsp_rgb565
);

   localparam int unsigned IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam logic [INDEX_W:0] ENTRY_LIMIT = (INDEX_W+1)'(PALETTE_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(PALETTE_ENTRIES - 1);

   // sequencer and per-entry valid flags
   state_type                  state_ff, state_in;
   logic [PALETTE_ENTRIES-1:0] vld_ff, vld_in;
   logic                       vld_q_ff, vld_rd;

   // work registers
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   logic [DIST_W-1:0]  best_dist_ff, best_dist_in;
   logic [RGB_W-1:0]   packed_ff, packed_in;
   logic               in_range_ff, in_range_in;
   entry_type          tgt_ff, tgt_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [DIST_W-1:0]  rsp_dist_ff, rsp_dist_in;
   logic [RGB_W-1:0]   rsp_rgb_ff, rsp_rgb_in;

   // palette RAM
   logic             ram_we;
   logic [IDX_W-1:0] ram_wr_addr, ram_rd_addr;
   entry_type        ram_wr_data, ram_rd_data, ent;

   // shared distance unit
   logic [CHAN_W-1:0] ad_r, ad_g, ad_b;
   logic [DIST_W-1:0] l1_dist;
   logic              take;

   logic accept, req_in_range;

   pnc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (PALETTE_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_ready    = (state_ff == ST_IDLE);
   assign accept       = req_valid && req_ready;
   assign req_in_range = ({1'b0, req_entry_index} < ENTRY_LIMIT);

   assign ram_wr_addr = req_entry_index[IDX_W-1:0];
   assign ram_wr_data = '{red: req_red, green: req_green, blue: req_blue};

   // Read address: the requested entry (entry zero for a search) on acceptance,
   // else one ahead of the compared entry so the registered read tracks the sweep.
   always_comb begin
      if (state_ff == ST_IDLE) begin
         ram_rd_addr = (action_type'(req_action) == ACT_SEARCH) ? '0
                                                                 : req_entry_index[IDX_W-1:0];
      end else begin
         ram_rd_addr = cmp_idx_ff + IDX_W'(1);
      end
   end

   // an entry never written since reset reads as black
   assign vld_rd = ((INDEX_W+1)'(ram_rd_addr) < ENTRY_LIMIT) ? vld_ff[ram_rd_addr] : 1'b0;
   assign ent    = vld_q_ff ? ram_rd_data : '0;

   // L1 distance of the entry under compare against the target colour
   assign ad_r = (tgt_ff.red   > ent.red)   ? tgt_ff.red   - ent.red   : ent.red   - tgt_ff.red;
   assign ad_g = (tgt_ff.green > ent.green) ? tgt_ff.green - ent.green : ent.green - tgt_ff.green;
   assign ad_b = (tgt_ff.blue  > ent.blue)  ? tgt_ff.blue  - ent.blue  : ent.blue  - tgt_ff.blue;
   assign l1_dist = DIST_W'(ad_r) + DIST_W'(ad_g) + DIST_W'(ad_b);
   // strict less-than keeps the lowest index on a tie
   assign take = (cmp_idx_ff == '0) || (l1_dist < best_dist_ff);

   always_comb begin
      state_in     = state_ff;
      vld_in       = vld_ff;
      cmp_idx_in   = cmp_idx_ff;
      best_idx_in  = best_idx_ff;
      best_dist_in = best_dist_ff;
      packed_in    = packed_ff;
      in_range_in  = in_range_ff;
      tgt_in       = tgt_ff;
      rsp_index_in = rsp_index_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_rgb_in   = rsp_rgb_ff;
      rsp_valid_in = rsp_valid_ff;
      ram_we       = 1'b0;

      // drop the result once the receiver takes it
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               tgt_in       = ram_wr_data;
               in_range_in  = req_in_range;
               best_idx_in  = '0;
               best_dist_in = '0;
               packed_in    = '0;
               cmp_idx_in   = '0;
               case (action_type'(req_action))
                  ACT_WRITE: begin
                     // out-of-range writes are ignored but still answered
                     if (req_in_range) begin
                        ram_we = 1'b1;
                        vld_in[req_entry_index[IDX_W-1:0]] = 1'b1;
                     end
                     state_in = ST_FINISH;
                  end
                  ACT_TRANSLATE: state_in = ST_XLATE;
                  ACT_SEARCH:    state_in = ST_SCAN;
                  default:       state_in = ST_FINISH;
               endcase
            end
         end
         ST_XLATE: begin
            packed_in = in_range_ff ? {ent.red[7:3], ent.green[7:2], ent.blue[7:3]} : '0;
            state_in  = ST_FINISH;
         end
         ST_SCAN: begin
            if (take) begin
               best_idx_in  = cmp_idx_ff;
               best_dist_in = l1_dist;
            end
            if (cmp_idx_ff == LAST_IDX) begin
               state_in = ST_FINISH;
            end else begin
               cmp_idx_in = cmp_idx_ff + IDX_W'(1);
            end
         end
         ST_FINISH: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_index_in = INDEX_W'(best_idx_ff);
               rsp_dist_in  = best_dist_ff;
               rsp_rgb_in   = packed_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vld_ff       <= '0;
         vld_q_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vld_ff       <= vld_in;
         vld_q_ff     <= vld_rd;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff   <= cmp_idx_in;
      best_idx_ff  <= best_idx_in;
      best_dist_ff <= best_dist_in;
      packed_ff    <= packed_in;
      in_range_ff  <= in_range_in;
      tgt_ff       <= tgt_in;
      rsp_index_ff <= rsp_index_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_rgb_ff   <= rsp_rgb_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_best_index    = rsp_index_ff;
   assign rsp_best_distance = rsp_dist_ff;
   assign rsp_rgb565        = rsp_rgb_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------

   // an accepted item always moves the sequencer out of idle
   a_accept_leaves_idle : assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("accepted item did not start the sequencer");

   // the sweep never runs past the last palette entry
   a_scan_in_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (cmp_idx_ff <= LAST_IDX))
      else $error("search index past the palette");

   // a translate result never carries search fields
   a_rgb_excludes_search : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_rgb_ff != '0)) |-> (rsp_index_ff == '0 && rsp_dist_ff == '0))
      else $error("translate result carries search fields");

   // a pending result is not overwritten while the receiver stalls
   a_rsp_held : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_dist_ff)
                                        && $stable(rsp_index_ff) && $stable(rsp_rgb_ff)))
      else $error("stalled result changed");

endmodule

@@ dv/palette_nearest_color_engine_core_tb.sv @@
// ----------------------------------------------------------------------------
// palette_nearest_color_engine_core_tb
// Checks palette writes, RGB565 translates and nearest colour searches. A
// directed table opens the run, then random items follow. Both handshakes
// stall at random. Every result is compared with a typed-in answer or a local palette model.
// ----------------------------------------------------------------------------
module palette_nearest_color_engine_core_tb
   import pnc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned PALETTE_ENTRIES  = 256;
   localparam int unsigned CLOCK_PERIOD     = 10;
   localparam int unsigned RANDOM_ITEMS     = 930;
   localparam int unsigned HOLD_AT_ITEM     = 300;   // receiver goes quiet here
   localparam int unsigned PAUSE_AT_ITEM    = 650;   // sender drains the block here
   localparam int unsigned LONG_HOLD_CYCLES = 600;
   localparam int unsigned DRAIN_CYCLES     = PALETTE_ENTRIES + 40;
   localparam int unsigned CYCLE_LIMIT      = 1_500_000;
   localparam int unsigned MAX_GAP          = 8;

   // action code 3 is not decoded by the block
   localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

   typedef struct packed {
      logic [INDEX_W-1:0] best_index;
      logic [DIST_W-1:0]  best_distance;
      logic [RGB_W-1:0]   rgb565;
   } answer_type;

   // one row of the directed table; fixed rows carry their answer typed in
   typedef struct {
      logic [ACT_W-1:0]   act;
      logic [INDEX_W-1:0] index;
      logic [CHAN_W-1:0]  red;
      logic [CHAN_W-1:0]  green;
      logic [CHAN_W-1:0]  blue;
      bit                 fixed;
      answer_type         want;
   } probe_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [ACT_W-1:0]     req_action = ACT_WRITE;
   logic [INDEX_W-1:0]   req_entry_index = '0;
   logic [CHAN_W-1:0]    req_red = '0;
   logic [CHAN_W-1:0]    req_green = '0;
   logic [CHAN_W-1:0]    req_blue = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [INDEX_W-1:0]   rsp_best_index;
   logic [DIST_W-1:0]    rsp_best_distance;
   logic [RGB_W-1:0]     rsp_rgb565;

   entry_type            palette_shadow [PALETTE_ENTRIES];
   answer_type           pending_answers [$];
   probe_type            directed_probes [$];
   int unsigned          mismatch_count = 0;
   int unsigned          cycle_count = 0;
   bit                   hold_off_armed = 1'b0;

   palette_nearest_color_engine_core #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_entry_index   (req_entry_index),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_best_index    (rsp_best_index),
      .rsp_best_distance (rsp_best_distance),
      .rsp_rgb565        (rsp_rgb565)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Watchdog: end the run if the block stops answering.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic int unsigned chan_gap(input logic [CHAN_W-1:0] a,
                                            input logic [CHAN_W-1:0] b);
      return (a > b) ? unsigned'(int'(a) - int'(b)) : unsigned'(int'(b) - int'(a));
   endfunction

   // Apply one item to the shadow palette and work out its answer. Writes and
   // the spare code answer all zero; a search walks the whole palette and
   // keeps the first entry at the least distance.
   function automatic answer_type resolve_palette_item(input logic [ACT_W-1:0]   act,
                                                       input logic [INDEX_W-1:0] index,
                                                       input logic [CHAN_W-1:0]  red,
                                                       input logic [CHAN_W-1:0]  green,
                                                       input logic [CHAN_W-1:0]  blue);
      answer_type  ans;
      int unsigned l1_sum;
      entry_type   cur;
      ans = '0;
      if (act == ACT_WRITE) begin
         if (index < PALETTE_ENTRIES) palette_shadow[index] = '{red, green, blue};
      end else if (act == ACT_TRANSLATE) begin
         if (index < PALETTE_ENTRIES) begin
            cur = palette_shadow[index];
            ans.rgb565 = {cur.red[CHAN_W-1 -: 5], cur.green[CHAN_W-1 -: 6],
                          cur.blue[CHAN_W-1 -: 5]};
         end
      end else if (act == ACT_SEARCH) begin
         for (int i = 0; i < PALETTE_ENTRIES; i++) begin
            cur    = palette_shadow[i];
            l1_sum = chan_gap(red, cur.red) + chan_gap(green, cur.green)
                   + chan_gap(blue, cur.blue);
            if (i == 0 || l1_sum < ans.best_distance) begin
               ans.best_distance = DIST_W'(l1_sum);
               ans.best_index    = INDEX_W'(i);
            end
         end
      end
      return ans;
   endfunction

   // Bias channels towards the extremes so both ends show up often.
   function automatic logic [CHAN_W-1:0] draw_channel();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      return CHAN_W'($urandom_range(0, 255));
   endfunction

   // Nudge a stored channel a few steps, clamped to the channel range.
   function automatic logic [CHAN_W-1:0] near_channel(input logic [CHAN_W-1:0] c);
      int v;
      v = int'(c) + int'($urandom_range(0, 8)) - 4;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return CHAN_W'(v);
   endfunction

   // Offer one item after a random gap, hold it until taken, then record what
   // the block should answer. Valid stays high into the next item when the
   // next gap is zero, so it is never dropped and raised in one step.
   int unsigned send_calm = 0;

   task automatic offer_item(input logic [ACT_W-1:0]   act,
                             input logic [INDEX_W-1:0] index,
                             input logic [CHAN_W-1:0]  red,
                             input logic [CHAN_W-1:0]  green,
                             input logic [CHAN_W-1:0]  blue,
                             input bit                 fixed,
                             input answer_type         want);
      int unsigned gap;
      answer_type  predicted;
      if (send_calm == 0 && $urandom_range(0, 19) == 0) send_calm = 16;
      if (send_calm > 0) begin
         send_calm--;
         gap = 0;
      end else begin
         gap = $urandom_range(0, MAX_GAP);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= act;
      req_entry_index <= index;
      req_red         <= red;
      req_green       <= green;
      req_blue        <= blue;
      do @(posedge clock); while (!req_ready);
      predicted = resolve_palette_item(act, index, red, green, blue);
      pending_answers.push_back(fixed ? want : predicted);
   endtask

   // Stimulus: directed table first, then random items.
   initial begin : stimulus
      probe_type          p;
      int unsigned        pick;
      logic [ACT_W-1:0]   act;
      logic [INDEX_W-1:0] index;
      logic [CHAN_W-1:0]  red, green, blue;
      entry_type          src;

      foreach (palette_shadow[i]) palette_shadow[i] = '0;

      // After reset the palette is black throughout.
      directed_probes.push_back('{ACT_SEARCH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1,
                                  '{8'd0, 10'd0, 16'd0}});
      directed_probes.push_back('{ACT_SEARCH, 8'd0, 8'hff, 8'hff, 8'hff, 1'b1,
                                  '{8'd0, 10'd765, 16'd0}});
      directed_probes.push_back('{ACT_TRANSLATE, 8'd255, 8'hff, 8'hff, 8'hff, 1'b1,
                                  '{8'd0, 10'd0, 16'd0}});
      // spare code answers zero and leaves the palette alone
      directed_probes.push_back('{ACT_SPARE, 8'd0, 8'hff, 8'hff, 8'hff, 1'b1,
                                  '{8'd0, 10'd0, 16'd0}});
      directed_probes.push_back('{ACT_WRITE, 8'd0, 8'hff, 8'hff, 8'hff, 1'b1,
                                  '{8'd0, 10'd0, 16'd0}});
      directed_probes.push_back('{ACT_TRANSLATE, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1,
                                  '{8'd0, 10'd0, 16'hffff}});
      // lowest bit that survives packing in each channel
      directed_probes.push_back('{ACT_WRITE, 8'd255, 8'h08, 8'h04, 8'h08, 1'b1,
                                  '{8'd0, 10'd0, 16'd0}});
      directed_probes.push_back('{ACT_TRANSLATE, 8'd255, 8'd0, 8'd0, 8'd0, 1'b1,
                                  '{8'd0, 10'd0, 16'h0821}});
      directed_probes.push_back('{ACT_SPARE, 8'd0, 8'h00, 8'h00, 8'h00, 1'b1,
                                  '{8'd0, 10'd0, 16'd0}});
      directed_probes.push_back('{ACT_TRANSLATE, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1,
                                  '{8'd0, 10'd0, 16'hffff}});
      // Searches ignore the index field; ties go to the lowest entry.
      directed_probes.push_back('{ACT_SEARCH, 8'haa, 8'd0, 8'd0, 8'd0, 1'b1,
                                  '{8'd1, 10'd0, 16'd0}});
      directed_probes.push_back('{ACT_SEARCH, 8'h55, 8'hff, 8'hff, 8'hff, 1'b1,
                                  '{8'd0, 10'd0, 16'd0}});
      directed_probes.push_back('{ACT_WRITE, 8'd128, 8'h80, 8'h80, 8'h80, 1'b1,
                                  '{8'd0, 10'd0, 16'd0}});
      directed_probes.push_back('{ACT_SEARCH, 8'd0, 8'h80, 8'h80, 8'h80, 1'b1,
                                  '{8'd128, 10'd0, 16'd0}});
      directed_probes.push_back('{ACT_WRITE, 8'd1, 8'h10, 8'h20, 8'h30, 1'b0, '0});
      directed_probes.push_back('{ACT_WRITE, 8'd2, 8'h7f, 8'h01, 8'hfe, 1'b0, '0});
      directed_probes.push_back('{ACT_SEARCH, 8'd0, 8'h11, 8'h1f, 8'h33, 1'b0, '0});
      directed_probes.push_back('{ACT_TRANSLATE, 8'd2, 8'd0, 8'd0, 8'd0, 1'b0, '0});
      directed_probes.push_back('{ACT_WRITE, 8'd3, 8'h7f, 8'h01, 8'hfe, 1'b0, '0});
      directed_probes.push_back('{ACT_SEARCH, 8'hff, 8'h7f, 8'h01, 8'hfe, 1'b0, '0});
      directed_probes.push_back('{ACT_SEARCH, 8'd0, 8'h40, 8'hc0, 8'h40, 1'b0, '0});
      directed_probes.push_back('{ACT_TRANSLATE, 8'd1, 8'd0, 8'd0, 8'd0, 1'b0, '0});

      // Hold reset at the start, then release it once.
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_probes[i]) begin
         p = directed_probes[i];
         offer_item(p.act, p.index, p.red, p.green, p.blue, p.fixed, p.want);
      end

      // Random part: writes (the largest share) that fill the palette, searches aimed near
      // stored colours so the nearest entry is not always entry zero, and
      // copies of stored colours so ties keep turning up.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == HOLD_AT_ITEM) hold_off_armed = 1'b1;
         if (n == PAUSE_AT_ITEM) begin
            req_valid <= 1'b0;
            wait (pending_answers.size() == 0);
            @(posedge clock);
         end
         pick  = $urandom_range(0, 99);
         index = INDEX_W'($urandom_range(0, 255));
         src   = palette_shadow[$urandom_range(0, PALETTE_ENTRIES - 1)];
         red   = draw_channel();
         green = draw_channel();
         blue  = draw_channel();
         if (pick < 45) begin
            act = ACT_WRITE;
            if ($urandom_range(0, 6) == 0) {red, green, blue} = src;
         end else if (pick < 68) begin
            act = ACT_TRANSLATE;
         end else if (pick < 94) begin
            act = ACT_SEARCH;
            if ($urandom_range(0, 4) < 3) begin
               red   = near_channel(src.red);
               green = near_channel(src.green);
               blue  = near_channel(src.blue);
            end
         end else begin
            act = ACT_SPARE;
         end
         offer_item(act, index, red, green, blue, 1'b0, '0);
      end

      // Drain, then keep watching for any stray result before ending.
      req_valid <= 1'b0;
      wait (pending_answers.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Result side: stall at random, once for a long stretch so the block backs
   // up into its input, and check each taken item against the oldest answer.
   initial begin : answer_checker
      int unsigned stall;
      int unsigned recv_calm;
      answer_type  want;
      recv_calm = 0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (recv_calm == 0 && $urandom_range(0, 19) == 0) recv_calm = 16;
         if (recv_calm > 0) begin
            recv_calm--;
            stall = 0;
         end else begin
            stall = $urandom_range(0, MAX_GAP);
         end
         if (hold_off_armed) begin
            hold_off_armed = 1'b0;
            stall = LONG_HOLD_CYCLES;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (pending_answers.size() == 0) begin
            $error("unexpected result: best_index %0d best_distance %0d rgb565 %h",
                   rsp_best_index, rsp_best_distance, rsp_rgb565);
            mismatch_count++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_best_index !== want.best_index) begin
               $error("best_index: expected %0d, got %0d", want.best_index, rsp_best_index);
               mismatch_count++;
            end
            if (rsp_best_distance !== want.best_distance) begin
               $error("best_distance: expected %0d, got %0d",
                      want.best_distance, rsp_best_distance);
               mismatch_count++;
            end
            if (rsp_rgb565 !== want.rgb565) begin
               $error("rgb565: expected %h, got %h", want.rgb565, rsp_rgb565);
               mismatch_count++;
            end
         end
      end
   end

endmodule
